>>> rtl/core/evp_pkg.sv
// Shared types, widths and register codes for the energy VAD with pre-roll.
package evp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int THR_W       = 31;
  localparam int TIMEOUT_W   = 20;
  localparam int PREROLL_W   = 6;
  localparam int SR_W        = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int MUL_A_W     = THR_W;
  localparam int MUL_B_W     = SAMPLE_BITS;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREROLL   = 2'd2;

  localparam logic [THR_W-1:0]     THRESHOLD_RST = 31'd429497;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd12800;
  localparam logic [PREROLL_W-1:0] PREROLL_RST   = 6'd32;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          utterance_start;
    logic                          utterance_end;
    logic                          burst_last;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]     energy_threshold_sq;
    logic [TIMEOUT_W-1:0] silence_timeout_samples;
    logic [PREROLL_W-1:0] preroll_len;
  } cfg_t;

endpackage

>>> rtl/core/evp_cfg_regs.sv
// Configuration register file written through the plain write port.
module evp_cfg_regs
  import evp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_threshold_sq     <= THRESHOLD_RST;
      cfg.silence_timeout_samples <= TIMEOUT_RST;
      cfg.preroll_len             <= PREROLL_RST;
    end else if (we) begin
      case (index)
        REG_THRESHOLD: cfg.energy_threshold_sq     <= data[THR_W-1:0];
        REG_TIMEOUT:   cfg.silence_timeout_samples <= data[TIMEOUT_W-1:0];
        REG_PREROLL:   cfg.preroll_len             <= data[PREROLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/evp_mul_unit.sv
// Shared registered multiplier for sample squares and threshold scaling.
module evp_mul_unit
  import evp_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> rtl/core/evp_out_stage.sv
// Output register that holds one result until the downstream transfer.
module evp_out_stage
  import evp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t item,
  output logic      free,
  output logic      valid,
  output out_item_t data,
  input  logic      stall
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= item;
    end
  end

endmodule

>>> rtl/core/energy_vad_with_preroll.sv
// Top level of the energy voice-activity detector with pre-roll and hangover.
//
// Samples arrive one per transfer and are buffered per frame; a frame closes on
// frame_last or after FRAME_MAX samples. A sample that does not close a frame
// is accepted, squared in the shared multiplier and accumulated. A sample that
// closes a frame then has the same multiplier scale the threshold by the frame
// length, the energy compared and the next action chosen; after that each
// sample moved is read from the frame or pre-roll memory before it is loaded
// into the output register or written into the ring. The ring samples and the
// frame are moved at speech onset, the frame alone while speaking or while
// filling the ring, and the output may be held by result_stall. sample_stall
// stays high until that work is done. A result is delivered through an output
// register, so the next sample is taken while the last result of a burst still
// waits. Writing preroll_len empties the ring.
module energy_vad_with_preroll
  import evp_pkg::*;
#(
  parameter int FRAME_MAX     = 16,
  parameter int PREROLL_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  in_item_t              sample_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = $clog2(FRAME_MAX + 1);
  localparam int FAW    = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam int RS_W   = $clog2(PREROLL_DEPTH + 1);
  localparam int RAW    = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
  localparam int ESUM_W = SQ_W + $clog2(FRAME_MAX);

  localparam logic [PREROLL_W-1:0] DepthCfg = PREROLL_W'(PREROLL_DEPTH);
  localparam logic [LEN_W-1:0]     FrameMaxLen = LEN_W'(FRAME_MAX);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SQ       = 4'd1;
  localparam logic [3:0] ST_ACC      = 4'd2;
  localparam logic [3:0] ST_THR      = 4'd3;
  localparam logic [3:0] ST_CMP      = 4'd4;
  localparam logic [3:0] ST_DECIDE   = 4'd5;
  localparam logic [3:0] ST_RING_RD  = 4'd6;
  localparam logic [3:0] ST_RING_OUT = 4'd7;
  localparam logic [3:0] ST_FRM_RD   = 4'd8;
  localparam logic [3:0] ST_FRM_OUT  = 4'd9;
  localparam logic [3:0] ST_RW_RD    = 4'd10;
  localparam logic [3:0] ST_RW_WR    = 4'd11;

  cfg_t cfg;

  logic [3:0]             state;
  logic [SAMPLE_BITS-1:0] mag;
  logic [LEN_W-1:0]       fill;
  logic [LEN_W-1:0]       len;
  logic                   end_flag;
  logic [ESUM_W-1:0]      energy_sum;
  logic                   is_speech;
  logic                   speaking;
  logic [SR_W-1:0]        silent_run;
  logic                   ended;
  logic                   first;
  logic [LEN_W-1:0]       idx;
  logic [RS_W-1:0]        ring_wp;
  logic [RS_W-1:0]        ring_stored;
  logic [RS_W-1:0]        ring_pos;
  logic [RS_W-1:0]        ring_cnt;

  logic [SAMPLE_BITS-1:0] frame_mem [FRAME_MAX];
  logic [SAMPLE_BITS-1:0] ring_mem [PREROLL_DEPTH];
  logic [SAMPLE_BITS-1:0] frame_rdata;
  logic [SAMPLE_BITS-1:0] ring_rdata;

  logic                   sample_fire;
  logic [SAMPLE_BITS-1:0] s_bits;
  logic [SAMPLE_BITS-1:0] s_abs;
  logic [LEN_W-1:0]       fill_plus;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     prod;
  logic [RS_W-1:0]        rs;
  logic [RS_W-1:0]        wp_norm;
  logic [RS_W-1:0]        st_norm;
  logic [RS_W:0]          pos_sum;
  logic [RS_W:0]          pos_wrap;
  logic [SR_W:0]          sr_sum;
  logic [SR_W-1:0]        sr_sat;
  logic                   timeout_hit;
  logic [RS_W-1:0]        wp_inc;
  logic [RS_W-1:0]        pos_inc;
  logic [LEN_W-1:0]       idx_inc;
  logic                   frame_done;
  logic                   out_free;
  logic                   out_load;
  out_item_t              out_item;

  evp_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  evp_mul_unit u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  evp_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .item  (out_item),
    .free  (out_free),
    .valid (result_valid),
    .data  (result_data),
    .stall (result_stall)
  );

  assign sample_stall = (state != ST_IDLE);
  assign sample_fire  = sample_valid && !sample_stall;
  assign s_bits       = sample_data.sample_in;
  assign s_abs        = s_bits[SAMPLE_BITS-1] ? (~s_bits + 1'b1) : s_bits;
  assign fill_plus    = fill + 1'b1;

  assign mul_a = (state == ST_THR) ? cfg.energy_threshold_sq : MUL_A_W'(mag);
  assign mul_b = (state == ST_THR) ? MUL_B_W'(len) : mag;

  assign rs = (cfg.preroll_len > DepthCfg) ? RS_W'(PREROLL_DEPTH) : RS_W'(cfg.preroll_len);

  assign wp_norm  = (ring_wp >= rs) ? '0 : ring_wp;
  assign st_norm  = (ring_stored > rs) ? rs : ring_stored;
  assign pos_sum  = {1'b0, wp_norm} + {1'b0, rs} - {1'b0, st_norm};
  assign pos_wrap = (pos_sum >= {1'b0, rs}) ? (pos_sum - {1'b0, rs}) : pos_sum;

  assign sr_sum      = {1'b0, silent_run} + (SR_W + 1)'(len);
  assign sr_sat      = sr_sum[SR_W] ? '1 : sr_sum[SR_W-1:0];
  assign timeout_hit = (sr_sat >= SR_W'(cfg.silence_timeout_samples));

  assign wp_inc     = ring_wp + 1'b1;
  assign pos_inc    = ring_pos + 1'b1;
  assign idx_inc    = idx + 1'b1;
  assign frame_done = (idx_inc == len);

  always_comb begin
    out_item.sample_out      = frame_rdata;
    out_item.utterance_start = first;
    out_item.utterance_end   = ended && frame_done;
    out_item.burst_last      = frame_done;
    if (state == ST_RING_OUT) begin
      out_item.sample_out    = ring_rdata;
      out_item.utterance_end = 1'b0;
      out_item.burst_last    = 1'b0;
    end
  end

  assign out_load = out_free && ((state == ST_RING_OUT) || (state == ST_FRM_OUT));

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      frame_mem[fill[FAW-1:0]] <= s_bits;
    end
    if ((state == ST_FRM_RD) || (state == ST_RW_RD)) begin
      frame_rdata <= frame_mem[idx[FAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RW_WR) begin
      ring_mem[ring_wp[RAW-1:0]] <= frame_rdata;
    end
    if (state == ST_RING_RD) begin
      ring_rdata <= ring_mem[ring_pos[RAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mag         <= '0;
      fill        <= '0;
      len         <= '0;
      end_flag    <= 1'b0;
      energy_sum  <= '0;
      is_speech   <= 1'b0;
      speaking    <= 1'b0;
      silent_run  <= '0;
      ended       <= 1'b0;
      first       <= 1'b0;
      idx         <= '0;
      ring_wp     <= '0;
      ring_stored <= '0;
      ring_pos    <= '0;
      ring_cnt    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_fire) begin
            mag      <= s_abs;
            len      <= fill_plus;
            end_flag <= sample_data.frame_last || (fill_plus == FrameMaxLen);
            if (sample_data.frame_last || (fill_plus == FrameMaxLen)) begin
              fill <= '0;
            end else begin
              fill <= fill_plus;
            end
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          energy_sum <= energy_sum + ESUM_W'(prod[SQ_W-1:0]);
          state      <= end_flag ? ST_THR : ST_IDLE;
        end
        ST_THR: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          is_speech  <= (MUL_P_W'(energy_sum) >= prod);
          energy_sum <= '0;
          state      <= ST_DECIDE;
        end
        ST_DECIDE: begin
          idx   <= '0;
          ended <= 1'b0;
          if (!speaking) begin
            ring_wp     <= wp_norm;
            ring_stored <= st_norm;
            if (is_speech) begin
              speaking   <= 1'b1;
              silent_run <= '0;
              first      <= 1'b1;
              ring_pos   <= pos_wrap[RS_W-1:0];
              ring_cnt   <= st_norm;
              state      <= (st_norm != '0) ? ST_RING_RD : ST_FRM_RD;
            end else begin
              state <= (rs != '0) ? ST_RW_RD : ST_IDLE;
            end
          end else begin
            first <= 1'b0;
            if (is_speech) begin
              silent_run <= '0;
            end else if (timeout_hit) begin
              ended       <= 1'b1;
              speaking    <= 1'b0;
              silent_run  <= '0;
              ring_stored <= '0;
              ring_wp     <= '0;
            end else begin
              silent_run <= sr_sat;
            end
            state <= ST_FRM_RD;
          end
        end
        ST_RING_RD: begin
          state <= ST_RING_OUT;
        end
        ST_RING_OUT: begin
          if (out_free) begin
            first    <= 1'b0;
            ring_cnt <= ring_cnt - 1'b1;
            ring_pos <= (pos_inc >= rs) ? '0 : pos_inc;
            state    <= (ring_cnt == RS_W'(1)) ? ST_FRM_RD : ST_RING_RD;
          end
        end
        ST_FRM_RD: begin
          state <= ST_FRM_OUT;
        end
        ST_FRM_OUT: begin
          if (out_free) begin
            first <= 1'b0;
            idx   <= idx_inc;
            state <= frame_done ? ST_IDLE : ST_FRM_RD;
          end
        end
        ST_RW_RD: begin
          state <= ST_RW_WR;
        end
        ST_RW_WR: begin
          ring_wp <= (wp_inc >= rs) ? '0 : wp_inc;
          if (ring_stored < rs) begin
            ring_stored <= ring_stored + 1'b1;
          end
          idx   <= idx_inc;
          state <= frame_done ? ST_IDLE : ST_RW_RD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we && (cfg_index == REG_PREROLL)) begin
        ring_stored <= '0;
        ring_wp     <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ring_stored <= rs))
    else $error("pre-roll count exceeds ring size while idle");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (fill == '0)) |-> (energy_sum == '0))
    else $error("energy sum not cleared at frame start");

  a_start_speaking: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item.utterance_start) |-> speaking)
    else $error("utterance start emitted while silent");

  a_end_silent: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item.utterance_end) |=> (!speaking && (state == ST_IDLE)))
    else $error("utterance end did not return to silence");
`endif

endmodule

>>> test/tb_energy_vad_with_preroll.sv
`timescale 1ns / 100ps
// Testbench for energy_vad_with_preroll: directed and random frames checked against a predictor.
module tb_energy_vad_with_preroll;
  import evp_pkg::*;

  localparam int FRAME_MAX      = 16;
  localparam int PREROLL_DEPTH  = 32;
  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 20;
  localparam int NUM_PHASES     = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [SR_W-1:0]      HANG_MAX   = '1;

  typedef enum {FRAME_QUIET, FRAME_LOUD, FRAME_PEAK, FRAME_NOISE} frame_kind_e;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  in_item_t              sample_data  = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result_data;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  logic [THR_W-1:0]              thr_sq;
  logic [TIMEOUT_W-1:0]          timeout_len;
  logic [PREROLL_W-1:0]          preroll_cfg;
  logic signed [SAMPLE_BITS-1:0] frame_buf [FRAME_MAX];
  logic signed [SAMPLE_BITS-1:0] ring_buf [PREROLL_DEPTH];
  int unsigned                   fill_cnt;
  int unsigned                   ring_wr;
  int unsigned                   ring_cnt;
  longint unsigned               energy_acc;
  longint unsigned               hang_cnt;
  bit                            talking;
  out_item_t                     utterance_q [$];

  out_item_t head;
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  int        sent_items   = 0;
  int        stall_left   = 0;
  int        calm_left    = 0;
  int        rx_draw;
  bit        sender_calm  = 1'b0;

  always #10 clk = ~clk;

  energy_vad_with_preroll #(
    .FRAME_MAX    (FRAME_MAX),
    .PREROLL_DEPTH(PREROLL_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_data (sample_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic out_item_t emit(input logic signed [SAMPLE_BITS-1:0] s,
                                     input logic st, input logic en);
    out_item_t r;
    r.sample_out      = s;
    r.utterance_start = st;
    r.utterance_end   = en;
    r.burst_last      = 1'b0;
    return r;
  endfunction

  task automatic vad_track_sample(input in_item_t it);
    out_item_t   burst [FRAME_MAX + PREROLL_DEPTH];
    int          n;
    int          sv;
    int unsigned mag, len, rs, pos;
    bit          speech, ended;
    n   = 0;
    sv  = int'(it.sample_in);
    mag = (sv < 0) ? -sv : sv;
    frame_buf[fill_cnt % FRAME_MAX] = it.sample_in;
    fill_cnt++;
    energy_acc += 64'(mag * mag);
    if (!it.frame_last && fill_cnt < FRAME_MAX) return;

    len        = fill_cnt;
    speech     = energy_acc >= 64'(thr_sq) * 64'(len);
    fill_cnt   = 0;
    energy_acc = 0;

    if (!talking) begin
      rs = (int'(preroll_cfg) > PREROLL_DEPTH) ? PREROLL_DEPTH : int'(preroll_cfg);
      if (ring_wr >= rs) ring_wr = 0;
      if (ring_cnt > rs) ring_cnt = rs;
      if (speech) begin
        talking  = 1'b1;
        hang_cnt = 0;
        if (ring_cnt > 0) begin
          pos = ring_wr + rs - ring_cnt;
          if (pos >= rs) pos -= rs;
          for (int i = 0; i < ring_cnt; i++) begin
            burst[n] = emit(ring_buf[pos], n == 0, 1'b0);
            n++;
            pos++;
            if (pos >= rs) pos = 0;
          end
        end
        for (int i = 0; i < len; i++) begin
          burst[n] = emit(frame_buf[i], n == 0, 1'b0);
          n++;
        end
      end else if (rs > 0) begin
        for (int i = 0; i < len; i++) begin
          ring_buf[ring_wr] = frame_buf[i];
          ring_wr++;
          if (ring_wr >= rs) ring_wr = 0;
          if (ring_cnt < rs) ring_cnt++;
        end
      end
    end else begin
      ended = 1'b0;
      if (speech) begin
        hang_cnt = 0;
      end else begin
        hang_cnt += 64'(len);
        if (hang_cnt > 64'(HANG_MAX)) hang_cnt = 64'(HANG_MAX);
        if (hang_cnt >= 64'(timeout_len)) begin
          ended    = 1'b1;
          talking  = 1'b0;
          hang_cnt = 0;
          ring_cnt = 0;
          ring_wr  = 0;
        end
      end
      for (int i = 0; i < len; i++) begin
        burst[n] = emit(frame_buf[i], 1'b0, ended && (i + 1 == len));
        n++;
      end
    end

    if (n > 0) begin
      burst[n-1].burst_last = 1'b1;
      for (int i = 0; i < n; i++) utterance_q.insert(utterance_q.size(), burst[i]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr_sq = val[THR_W-1:0];
      REG_TIMEOUT:   timeout_len = val[TIMEOUT_W-1:0];
      REG_PREROLL: begin
        preroll_cfg = val[PREROLL_W-1:0];
        ring_cnt    = 0;
        ring_wr     = 0;
      end
      default: ;
    endcase
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [TIMEOUT_W-1:0] tmo,
                           input logic [PREROLL_W-1:0] pre);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(REG_PREROLL, CFG_DATA_W'(pre));
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fl);
    in_item_t it;
    int       gap;
    it.sample_in  = s;
    it.frame_last = fl;
    gap = sender_calm ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    vad_track_sample(it);
    sent_items++;
  endtask

  // drain all results, then let the block finish any silent frame work
  task automatic settle();
    sample_valid <= 1'b0;
    while (utterance_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input frame_kind_e kind);
    int m;
    case (kind)
      FRAME_QUIET: m = $urandom_range(0, 255);
      FRAME_LOUD:  m = $urandom_range(16384, 32767);
      FRAME_PEAK:  return 16'sh8000;
      default:     return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
    return SAMPLE_BITS'($urandom_range(0, 1) ? -m : m);
  endfunction

  task automatic send_random_frame(input frame_kind_e kind);
    int unsigned len;
    bit          auto_close;
    if ($urandom_range(0, 9) == 0) kind = FRAME_NOISE;
    else if (kind == FRAME_LOUD && $urandom_range(0, 7) == 0) kind = FRAME_PEAK;
    len = ($urandom_range(0, 3) == 0) ? FRAME_MAX : $urandom_range(1, FRAME_MAX);
    auto_close  = (len == FRAME_MAX) && $urandom_range(0, 1);
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) send_sample(draw_sample(kind), !auto_close && i == len - 1);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    // full-scale frame closed by length alone
    for (int i = 0; i < FRAME_MAX; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, 1'b0);
    send_sample(16'sd0, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    configure(31'h40000000, 20'd0, 6'd0);
    write_reg(REG_UNUSED, '1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    settle();
    configure(31'h40000000, 20'd1, 6'd63);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, '0);
    send_sample(16'sd0, 1'b1);
    settle();
  endtask

  task automatic test_random_utterances();
    logic [THR_W-1:0]     thr_set [NUM_PHASES];
    logic [TIMEOUT_W-1:0] tmo_set [NUM_PHASES];
    logic [PREROLL_W-1:0] pre_set [NUM_PHASES];
    int                   start_items;
    thr_set = '{THRESHOLD_RST, 31'h100000, 31'h4000000, 31'd0, 31'h40000000,
                31'($urandom_range(32'h10000, 32'h10000000))};
    tmo_set = '{20'd40, 20'd0, 20'hFFFFF, 20'd24, 20'd1, 20'($urandom_range(1, 80))};
    pre_set = '{PREROLL_RST, 6'd5, 6'd0, 6'd63, 6'd1, 6'($urandom_range(0, 63))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(thr_set[p], tmo_set[p], pre_set[p]);
      start_items = sent_items;
      while (sent_items - start_items < PHASE_ITEMS) begin
        repeat ($urandom_range(0, 3)) send_random_frame(FRAME_QUIET);
        repeat ($urandom_range(1, 3)) send_random_frame(FRAME_LOUD);
        repeat ($urandom_range(0, 4)) send_random_frame(FRAME_QUIET);
      end
      settle();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (result_stall) begin
      if (stall_left == 0) result_stall <= 1'b0;
      else stall_left <= stall_left - 1;
    end else if (result_valid) begin
      if (calm_left > 0) begin
        calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        calm_left <= 24;
      end else begin
        rx_draw = $urandom_range(0, 13);
        if (rx_draw > 0) begin
          result_stall <= 1'b1;
          stall_left   <= rx_draw - 1;
        end
      end
    end else if ($urandom_range(0, 15) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (utterance_q.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected transfer: sample %0d start %b end %b last %b",
                   result_data.sample_out, result_data.utterance_start,
                   result_data.utterance_end, result_data.burst_last);
        mismatch_cnt++;
      end else begin
        head = utterance_q.pop_front();
        if (result_data.sample_out !== head.sample_out ||
            result_data.utterance_start !== head.utterance_start ||
            result_data.utterance_end !== head.utterance_end ||
            result_data.burst_last !== head.burst_last) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch: expected %0d/%b/%b/%b, got %0d/%b/%b/%b",
                     head.sample_out, head.utterance_start, head.utterance_end,
                     head.burst_last, result_data.sample_out, result_data.utterance_start,
                     result_data.utterance_end, result_data.burst_last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (sample_valid && !sample_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_energy_vad_with_preroll: FAIL");
      $finish;
    end
  end

  initial begin
    thr_sq      = THRESHOLD_RST;
    timeout_len = TIMEOUT_RST;
    preroll_cfg = PREROLL_RST;
    fill_cnt    = 0;
    ring_wr     = 0;
    ring_cnt    = 0;
    energy_acc  = 0;
    hang_cnt    = 0;
    talking     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_utterances();
    settle();
    if (mismatch_cnt == 0) begin
      $display("tb_energy_vad_with_preroll: PASS");
    end else begin
      $display("tb_energy_vad_with_preroll: FAIL");
    end
    $finish;
  end

endmodule
